@@ design/sal_pkg.sv @@
package sal_pkg;

  localparam int SLOTS_DEF = 32;
  localparam int VALUE_W   = 32;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 6;
  localparam int STEP_W    = 5;

  localparam logic FN_REMOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  typedef struct packed {
    logic                      func;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } out_item_t;

  // Program steps of the control store
  typedef enum logic [STEP_W-1:0] {
    S_IDLE      = 5'd0,
    S_DISP      = 5'd1,
    S_I_CHK     = 5'd2,
    S_I_POP     = 5'd3,
    S_I_TAKE    = 5'd4,
    S_W_START   = 5'd5,
    S_W_LOOP    = 5'd6,
    S_W_END     = 5'd7,
    S_I_LINK    = 5'd8,
    S_I_HEAD    = 5'd9,
    S_R_CHK     = 5'd10,
    S_R_EMPTY   = 5'd11,
    S_R_POST    = 5'd12,
    S_R_UNLINK  = 5'd13,
    S_R_FREE    = 5'd14,
    S_R_MISS    = 5'd15,
    S_I_FULL    = 5'd16,
    S_RESP      = 5'd17,
    S_RESP_WAIT = 5'd18
  } step_t;

  typedef enum logic [3:0] {
    A_NONE,
    A_IDLE,
    A_POP,
    A_TAKE,
    A_WSTART,
    A_WSTEP,
    A_I_LINK,
    A_I_HEAD,
    A_R_UNLINK,
    A_R_FREE,
    A_ST_EMPTY,
    A_ST_MISS,
    A_ST_FULL,
    A_RESP
  } act_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOT_ACC,
    C_REMOVE,
    C_FULL,
    C_HEAD_NIL,
    C_HEAD_VALID,
    C_WALK_MORE,
    C_NOT_FOUND,
    C_OUT_FREE
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic accept;
    logic remove;
    logic full;
    logic head_nil;
    logic walk_more;
    logic found;
    logic out_free;
  } flags_t;

endpackage

@@ design/sal_urom.sv @@
module sal_urom (
  input  sal_pkg::step_t  step,
  output sal_pkg::uword_t uw
);

  always_comb begin
    case (step)
      sal_pkg::S_IDLE:      uw = '{sal_pkg::A_IDLE,     sal_pkg::C_NOT_ACC,    sal_pkg::S_IDLE};
      sal_pkg::S_DISP:      uw = '{sal_pkg::A_NONE,     sal_pkg::C_REMOVE,     sal_pkg::S_R_CHK};
      sal_pkg::S_I_CHK:     uw = '{sal_pkg::A_NONE,     sal_pkg::C_FULL,       sal_pkg::S_I_FULL};
      sal_pkg::S_I_POP:     uw = '{sal_pkg::A_POP,      sal_pkg::C_NEVER,      sal_pkg::S_IDLE};
      sal_pkg::S_I_TAKE:    uw = '{sal_pkg::A_TAKE,     sal_pkg::C_NEVER,      sal_pkg::S_IDLE};
      sal_pkg::S_W_START:   uw = '{sal_pkg::A_WSTART,   sal_pkg::C_HEAD_NIL,   sal_pkg::S_W_END};
      sal_pkg::S_W_LOOP:    uw = '{sal_pkg::A_WSTEP,    sal_pkg::C_WALK_MORE,  sal_pkg::S_W_LOOP};
      sal_pkg::S_W_END:     uw = '{sal_pkg::A_NONE,     sal_pkg::C_REMOVE,     sal_pkg::S_R_POST};
      sal_pkg::S_I_LINK:    uw = '{sal_pkg::A_I_LINK,   sal_pkg::C_NEVER,      sal_pkg::S_IDLE};
      sal_pkg::S_I_HEAD:    uw = '{sal_pkg::A_I_HEAD,   sal_pkg::C_ALWAYS,     sal_pkg::S_RESP};
      sal_pkg::S_R_CHK:     uw = '{sal_pkg::A_NONE,     sal_pkg::C_HEAD_VALID, sal_pkg::S_W_START};
      sal_pkg::S_R_EMPTY:   uw = '{sal_pkg::A_ST_EMPTY, sal_pkg::C_ALWAYS,     sal_pkg::S_RESP};
      sal_pkg::S_R_POST:    uw = '{sal_pkg::A_NONE,     sal_pkg::C_NOT_FOUND,  sal_pkg::S_R_MISS};
      sal_pkg::S_R_UNLINK:  uw = '{sal_pkg::A_R_UNLINK, sal_pkg::C_NEVER,      sal_pkg::S_IDLE};
      sal_pkg::S_R_FREE:    uw = '{sal_pkg::A_R_FREE,   sal_pkg::C_ALWAYS,     sal_pkg::S_RESP};
      sal_pkg::S_R_MISS:    uw = '{sal_pkg::A_ST_MISS,  sal_pkg::C_ALWAYS,     sal_pkg::S_RESP};
      sal_pkg::S_I_FULL:    uw = '{sal_pkg::A_ST_FULL,  sal_pkg::C_NEVER,      sal_pkg::S_IDLE};
      sal_pkg::S_RESP:      uw = '{sal_pkg::A_RESP,     sal_pkg::C_OUT_FREE,   sal_pkg::S_IDLE};
      sal_pkg::S_RESP_WAIT: uw = '{sal_pkg::A_NONE,     sal_pkg::C_ALWAYS,     sal_pkg::S_RESP};
      default:              uw = '{sal_pkg::A_NONE,     sal_pkg::C_ALWAYS,     sal_pkg::S_IDLE};
    endcase
  end

endmodule

@@ design/sal_seq.sv @@
module sal_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  sal_pkg::uword_t  uw,
  input  sal_pkg::flags_t  flags,
  output sal_pkg::step_t   upc
);

  sal_pkg::step_t             upc_r;
  sal_pkg::step_t             upc_nxt;
  logic                       take;
  logic [sal_pkg::STEP_W-1:0] upc_inc;

  always_comb begin
    case (uw.cond)
      sal_pkg::C_NEVER:      take = 1'b0;
      sal_pkg::C_ALWAYS:     take = 1'b1;
      sal_pkg::C_NOT_ACC:    take = !flags.accept;
      sal_pkg::C_REMOVE:     take = flags.remove;
      sal_pkg::C_FULL:       take = flags.full;
      sal_pkg::C_HEAD_NIL:   take = flags.head_nil;
      sal_pkg::C_HEAD_VALID: take = !flags.head_nil;
      sal_pkg::C_WALK_MORE:  take = flags.walk_more;
      sal_pkg::C_NOT_FOUND:  take = !flags.found;
      sal_pkg::C_OUT_FREE:   take = flags.out_free;
      default:               take = 1'b0;
    endcase
  end

  assign upc_inc = upc_r + sal_pkg::STEP_W'(1);

  always_comb begin
    if (take) begin
      upc_nxt = uw.target;
    end else begin
      upc_nxt = sal_pkg::step_t'(upc_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= sal_pkg::S_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  assign upc = upc_r;

endmodule

@@ design/sal_dpath.sv @@
module sal_dpath #(
  parameter int SLOTS = sal_pkg::SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sal_pkg::act_t      act,
  input  logic               in_valid,
  output logic               in_ready,
  input  sal_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output sal_pkg::out_item_t out_item,
  output sal_pkg::flags_t    flags
);

  localparam int IW = $clog2(SLOTS);
  localparam int PW = $clog2(SLOTS + 1);
  localparam logic [PW-1:0] NIL  = PW'(SLOTS);
  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

  logic [PW-1:0]                     next_mem [SLOTS];
  logic signed [sal_pkg::VALUE_W-1:0] val_mem [SLOTS];

  logic                               func_r;
  logic signed [sal_pkg::VALUE_W-1:0] value_r;
  logic [PW-1:0]                      head_r;
  logic [PW-1:0]                      free_r;
  logic [PW-1:0]                      cnt_r;
  logic [PW-1:0]                      slot_r;
  logic [PW-1:0]                      cur_r;
  logic [PW-1:0]                      prev_r;
  logic [PW-1:0]                      nxt_r;
  logic [IW-1:0]                      steps_r;
  logic                               found_r;
  sal_pkg::status_t                   status_r;
  logic                               init_done_r;
  logic [IW-1:0]                      init_idx_r;
  logic                               out_valid_r;
  sal_pkg::out_item_t                 out_item_r;
  logic [PW-1:0]                      next_rd_r;
  logic signed [sal_pkg::VALUE_W-1:0] val_rd_r;

  logic          accept;
  logic          out_free;
  logic          hit;
  logic [PW-1:0] cur_norm;
  logic [PW-1:0] nxt_norm;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          nx_we;
  logic [IW-1:0] nx_addr;
  logic [PW-1:0] nx_data;

  function automatic logic ptr_ok(input logic [PW-1:0] p);
    return p < NIL;
  endfunction

  assign in_ready = (act == sal_pkg::A_IDLE) && init_done_r;
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Insert stops at the first element not smaller; remove at the first equal one
  assign hit = (func_r == sal_pkg::FN_REMOVE) ? (val_rd_r == value_r) : (val_rd_r >= value_r);

  assign cur_norm = ptr_ok(cur_r) ? cur_r : NIL;
  assign nxt_norm = ptr_ok(nxt_r) ? nxt_r : NIL;

  assign flags.accept    = accept;
  assign flags.remove    = (func_r == sal_pkg::FN_REMOVE);
  assign flags.full      = (cnt_r >= NIL) || !ptr_ok(free_r);
  assign flags.head_nil  = !ptr_ok(head_r);
  assign flags.walk_more = !hit && ptr_ok(next_rd_r) && (steps_r != LAST);
  assign flags.found     = found_r;
  assign flags.out_free  = out_free;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = free_r[IW-1:0];
    case (act)
      sal_pkg::A_POP: begin
        rd_en   = 1'b1;
        rd_addr = free_r[IW-1:0];
      end
      sal_pkg::A_WSTART: begin
        rd_en   = 1'b1;
        rd_addr = head_r[IW-1:0];
      end
      sal_pkg::A_WSTEP: begin
        rd_en   = 1'b1;
        rd_addr = next_rd_r[IW-1:0];
      end
      default: begin
        rd_en   = 1'b0;
      end
    endcase
  end

  always_comb begin
    nx_we   = 1'b0;
    nx_addr = init_idx_r;
    nx_data = PW'(init_idx_r) + PW'(1);
    if (!init_done_r) begin
      nx_we = 1'b1;
    end else begin
      case (act)
        sal_pkg::A_I_LINK: begin
          nx_we   = 1'b1;
          nx_addr = slot_r[IW-1:0];
          nx_data = cur_norm;
        end
        sal_pkg::A_I_HEAD: begin
          nx_we   = ptr_ok(prev_r);
          nx_addr = prev_r[IW-1:0];
          nx_data = slot_r;
        end
        sal_pkg::A_R_UNLINK: begin
          nx_we   = ptr_ok(prev_r);
          nx_addr = prev_r[IW-1:0];
          nx_data = nxt_norm;
        end
        sal_pkg::A_R_FREE: begin
          nx_we   = 1'b1;
          nx_addr = cur_r[IW-1:0];
          nx_data = free_r;
        end
        default: begin
          nx_we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (nx_we) begin
      next_mem[nx_addr] <= nx_data;
    end
    if (rd_en) begin
      next_rd_r <= next_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (act == sal_pkg::A_POP) begin
      val_mem[free_r[IW-1:0]] <= value_r;
    end
    if (rd_en) begin
      val_rd_r <= val_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_done_r <= 1'b0;
      init_idx_r  <= '0;
      head_r      <= NIL;
      free_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (!init_done_r) begin
        init_idx_r <= init_idx_r + IW'(1);
        if (init_idx_r == LAST) begin
          init_done_r <= 1'b1;
        end
      end
      case (act)
        sal_pkg::A_TAKE: begin
          free_r <= next_rd_r;
        end
        sal_pkg::A_I_HEAD: begin
          if (!ptr_ok(prev_r)) begin
            head_r <= slot_r;
          end
          cnt_r <= cnt_r + PW'(1);
        end
        sal_pkg::A_R_UNLINK: begin
          if (!ptr_ok(prev_r)) begin
            head_r <= nxt_norm;
          end
        end
        sal_pkg::A_R_FREE: begin
          free_r <= cur_r;
          if (cnt_r != '0) begin
            cnt_r <= cnt_r - PW'(1);
          end
        end
        default: begin
          head_r <= head_r;
        end
      endcase
      if ((act == sal_pkg::A_RESP) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r  <= in_item.func;
      value_r <= in_item.value;
    end
    case (act)
      sal_pkg::A_POP: begin
        slot_r <= free_r;
      end
      sal_pkg::A_WSTART: begin
        cur_r   <= head_r;
        prev_r  <= NIL;
        steps_r <= '0;
        found_r <= 1'b0;
      end
      sal_pkg::A_WSTEP: begin
        if (hit) begin
          found_r <= 1'b1;
          nxt_r   <= next_rd_r;
        end else begin
          prev_r  <= cur_r;
          cur_r   <= next_rd_r;
          steps_r <= steps_r + IW'(1);
        end
      end
      sal_pkg::A_I_HEAD:   status_r <= sal_pkg::ST_OK;
      sal_pkg::A_R_FREE:   status_r <= sal_pkg::ST_OK;
      sal_pkg::A_ST_EMPTY: status_r <= sal_pkg::ST_EMPTY;
      sal_pkg::A_ST_MISS:  status_r <= sal_pkg::ST_MISS;
      sal_pkg::A_ST_FULL:  status_r <= sal_pkg::ST_FULL;
      default: begin
        status_r <= status_r;
      end
    endcase
    if ((act == sal_pkg::A_RESP) && out_free) begin
      out_item_r.status <= status_r;
      out_item_r.count  <= sal_pkg::COUNT_W'(cnt_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ design/sorted_array_linked_list_top.sv @@
// Sorted linked list of SLOTS signed 32-bit values held in slot memories, with a
// free-slot chain. Each transaction is an insert (func 0) or a remove (func 1) and
// returns one result: status (ok, full, empty, not found) and the element count after
// the operation. A small microcoded sequencer drives the datapath; the list is walked
// one link per cycle through the registered read port of the link memory. After reset
// the link memory is initialized by a pass over all SLOTS entries, during which
// in_ready stays low. A finished result waits in an output register.
module sorted_array_linked_list_top #(
  parameter int SLOTS = sal_pkg::SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sal_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output sal_pkg::out_item_t out_item
);

  sal_pkg::step_t  upc;
  sal_pkg::uword_t uw;
  sal_pkg::flags_t flags;

  sal_urom u_urom (
    .step (upc),
    .uw   (uw)
  );

  sal_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .uw    (uw),
    .flags (flags),
    .upc   (upc)
  );

  sal_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .act       (uw.act),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .flags     (flags)
  );

`ifndef ASSERT_OFF
  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (upc == sal_pkg::S_DISP))
    else $error("accepted transaction did not dispatch");

  a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> ($past(upc) == sal_pkg::S_RESP))
    else $error("result loaded outside the response step");

  a_walk_stays: assert property (@(posedge clk) disable iff (!rst_n)
    ((upc == sal_pkg::S_W_LOOP) && flags.walk_more) |=> (upc == sal_pkg::S_W_LOOP))
    else $error("list walk left the loop early");
`endif

endmodule
